>>> rtl/ttsb_pkg.sv
package ttsb_pkg;

    localparam int MOVE_THR_W = 15;
    localparam int TAP_LIM_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LIMIT = 2'd1;

    localparam logic [MOVE_THR_W-1:0] MOVE_THR_RST  = 15'd10;
    localparam logic [TAP_LIM_W-1:0]  TAP_LIMIT_RST = 32'd308;

    typedef enum logic [1:0] {
        OP_DOWN  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_LIFT  = 2'd2,
        OP_FOCUS = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HOLD    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BTN_SELECT = 2'd0,
        BTN_UP     = 2'd1,
        BTN_DOWN   = 2'd2
    } t_btn;

    // One queued command: a click (press then release) or a sensor hold change
    typedef struct packed {
        logic is_hold;
        t_btn button;
        logic sensor_on;
    } t_cmd;

endpackage

>>> rtl/touch_tap_swipe_to_button.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: touch fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: event_kind; tdata; tlast
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// An input item is taken whenever the two-entry command queue has room, so items can
// follow back to back. A click leaves as two results (press, then release) and a sensor
// hold change as one; the back end's output register holds each result until it is taken.
// Reset is synchronous; no clearing pass, the block takes items the cycle after reset.
// A stalled output fills the queue and then holds s_axis_tready low.
module touch_tap_swipe_to_button #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // opcode
    input  logic [1:0]                                s_axis_tuser,
    // pos_x, pos_y, timestamp, gate_open, app_consumes_touch, focus_active, zero pad
    input  logic [((2*COORD_BITS+TIME_BITS+3+7)/8)*8-1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // event_kind
    output logic [1:0]                                m_axis_tuser,
    // button, sensor_on, zero pad
    output logic [7:0]                                m_axis_tdata,
    output logic                                      m_axis_tlast,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [ttsb_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [ttsb_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import ttsb_pkg::*;

    localparam int X_LO = 0;
    localparam int Y_LO = COORD_BITS;
    localparam int T_LO = 2*COORD_BITS;
    localparam int G_AT = 2*COORD_BITS + TIME_BITS;

    logic  push_valid, push_ready, pop_valid, pop;
    t_cmd  push_cmd, pop_cmd;
    t_kind out_kind;
    t_btn  out_button;
    logic  out_sensor_on;

    assign o_cfg_ready = 1'b1;

    ttsb_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (s_axis_tvalid),
        .o_ready              (s_axis_tready),
        .i_op                 (t_op'(s_axis_tuser)),
        .i_pos_x              (s_axis_tdata[X_LO +: COORD_BITS]),
        .i_pos_y              (s_axis_tdata[Y_LO +: COORD_BITS]),
        .i_timestamp          (s_axis_tdata[T_LO +: TIME_BITS]),
        .i_gate_open          (s_axis_tdata[G_AT]),
        .i_app_consumes_touch (s_axis_tdata[G_AT+1]),
        .i_focus_active       (s_axis_tdata[G_AT+2]),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_push_valid         (push_valid),
        .i_push_ready         (push_ready),
        .o_push_cmd           (push_cmd)
    );

    ttsb_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd)
    );

    ttsb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_pop   (pop),
        .i_cmd       (pop_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (out_kind),
        .o_button    (out_button),
        .o_sensor_on (out_sensor_on),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {5'd0, out_sensor_on, out_button};

endmodule

>>> rtl/ttsb_front.sv
module ttsb_front #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ttsb_pkg::t_op                 i_op,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic [TIME_BITS-1:0]          i_timestamp,
    input  logic                          i_gate_open,
    input  logic                          i_app_consumes_touch,
    input  logic                          i_focus_active,
    // configuration writes
    input  logic                          i_cfg_valid,
    input  logic [ttsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command queue push
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output ttsb_pkg::t_cmd                o_push_cmd
);
    import ttsb_pkg::*;

    logic [MOVE_THR_W-1:0]        r_move_thr;
    logic [TAP_LIM_W-1:0]         r_tap_limit;

    logic                         r_hold_active, n_hold_active;
    logic                         r_touching,    n_touching;
    logic                         r_dragging,    n_dragging;
    logic signed [COORD_BITS-1:0] r_start_x;
    logic signed [COORD_BITS-1:0] r_start_y;
    logic [TIME_BITS-1:0]         r_down_time;

    logic                         accept;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS:0]          adx, ady;
    logic [TIME_BITS-1:0]         elapsed;
    logic                         moved_far, is_tap, is_swipe;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_thr  <= MOVE_THR_RST;
            r_tap_limit <= TAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MOVE_THR:  r_move_thr  <= i_cfg_data[MOVE_THR_W-1:0];
                CFG_TAP_LIMIT: r_tap_limit <= i_cfg_data[TAP_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // exact differences, one bit wider than the coordinates
    assign dx  = {i_pos_x[COORD_BITS-1], i_pos_x} - {r_start_x[COORD_BITS-1], r_start_x};
    assign dy  = {i_pos_y[COORD_BITS-1], i_pos_y} - {r_start_y[COORD_BITS-1], r_start_y};
    assign adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
    assign ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);

    assign elapsed   = i_timestamp - r_down_time;
    assign moved_far = (32'(adx) > 32'(r_move_thr)) || (32'(ady) > 32'(r_move_thr));
    assign is_tap    = 64'(elapsed) < 64'(r_tap_limit);
    assign is_swipe  = (ady > adx) && (32'(ady) >= 32'(r_move_thr));

    always_comb begin
        n_hold_active = r_hold_active;
        n_touching    = r_touching;
        n_dragging    = r_dragging;
        o_push_valid  = 1'b0;
        o_push_cmd    = '{is_hold: 1'b0, button: BTN_SELECT, sensor_on: 1'b0};
        if (accept) begin
            if (i_op == OP_FOCUS) begin
                if (i_focus_active != r_hold_active) begin
                    n_hold_active = i_focus_active;
                    n_touching    = 1'b0;
                    n_dragging    = 1'b0;
                    o_push_valid  = 1'b1;
                    o_push_cmd    = '{is_hold: 1'b1, button: BTN_SELECT,
                                      sensor_on: i_focus_active};
                end
            end else if (!i_gate_open) begin
                n_touching = 1'b0;
                n_dragging = 1'b0;
            end else begin
                case (i_op)
                    OP_DOWN: begin
                        n_touching = 1'b1;
                        n_dragging = 1'b0;
                    end
                    OP_MOVE: begin
                        if (r_touching && !r_dragging && moved_far) begin
                            n_dragging = 1'b1;
                        end
                    end
                    OP_LIFT: begin
                        if (r_touching) begin
                            n_touching = 1'b0;
                            if (!i_app_consumes_touch) begin
                                if (!r_dragging) begin
                                    o_push_valid = is_tap;
                                end else begin
                                    o_push_valid = is_swipe;
                                    o_push_cmd.button = dy[COORD_BITS] ? BTN_UP : BTN_DOWN;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_active <= 1'b0;
            r_touching    <= 1'b0;
            r_dragging    <= 1'b0;
        end else begin
            r_hold_active <= n_hold_active;
            r_touching    <= n_touching;
            r_dragging    <= n_dragging;
        end
    end

    // start point and time: latch on an accepted touchdown with the gate open
    always_ff @(posedge i_clk) begin
        if (accept && i_op == OP_DOWN && i_gate_open) begin
            r_start_x   <= i_pos_x;
            r_start_y   <= i_pos_y;
            r_down_time <= i_timestamp;
        end
    end

endmodule

>>> rtl/ttsb_fifo.sv
module ttsb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ttsb_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output ttsb_pkg::t_cmd o_pop_cmd
);
    import ttsb_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/ttsb_back.sv
module ttsb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  ttsb_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output ttsb_pkg::t_kind o_kind,
    output ttsb_pkg::t_btn  o_button,
    output logic            o_sensor_on,
    output logic            o_last
);
    import ttsb_pkg::*;

    logic  r_valid;
    t_kind r_kind;
    t_btn  r_button;
    logic  r_sensor_on;
    logic  r_last;
    logic  r_phase;   // 1 once the press of a click has gone out
    logic  load;

    assign load      = i_cmd_valid && (!r_valid || i_ready);
    assign o_cmd_pop = load && (i_cmd.is_hold || r_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= !i_cmd.is_hold && !r_phase;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_cmd.is_hold) begin
                r_kind      <= KIND_HOLD;
                r_button    <= BTN_SELECT;
                r_sensor_on <= i_cmd.sensor_on;
                r_last      <= 1'b1;
            end else begin
                r_kind      <= r_phase ? KIND_RELEASE : KIND_PRESS;
                r_button    <= i_cmd.button;
                r_sensor_on <= 1'b0;
                r_last      <= r_phase;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_button    = r_button;
    assign o_sensor_on = r_sensor_on;
    assign o_last      = r_last;

endmodule
